@@ src/smbrw_pkg.sv @@
// Shared types, constants and CRC-8 helper for the SMBus read-word master.
package smbrw_pkg;

  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_LSB = 2;

  localparam logic [0:0] REG_DEVICE_ADDRESS   = 1'b0;
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h5A;

  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NACK_WADDR = 2'd1;
  localparam logic [1:0] STATUS_NACK_WREG  = 2'd2;
  localparam logic [1:0] STATUS_NACK_RADDR = 2'd3;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] reg_addr;
    logic       sda;
  } cmd_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] data_word;
    logic        pec_ok;
  } res_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ src/smbrw_if.sv @@
// Valid/ready channel interfaces for commands in and results out.
interface smbrw_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] reg_addr;
  logic       sda_in;

  modport source (output valid, output opcode, output reg_addr, output sda_in, input ready);
  modport sink (input valid, input opcode, input reg_addr, input sda_in, output ready);
endinterface

interface smbrw_out_if;
  logic        valid;
  logic        ready;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] data_word;
  logic        pec_ok;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output status, output data_word, output pec_ok,
                  input ready);
  modport sink (input valid, input scl_out, input sda_out, input busy_res,
                input done_res, input status, input data_word, input pec_ok,
                output ready);
endinterface

@@ src/smbus_read_word_pec_master_core.sv @@
// Top level: SMBus read-word master with PEC, APB register port and channel wiring.
// Each input transaction is either a phase tick or a start command and yields exactly one
// result transaction. Throughput is one transaction per clock when not stalled; an accepted
// transaction is held in the command queue and its result in the result register. The
// sequencer, including its CRC-8 update, is combinational between those two stores, so the
// only stalls come from a full command queue of QDEPTH entries behind a held result.
// The device address register sits at byte address 0 and must be written only while idle.
module smbus_read_word_pec_master_core #(
  parameter int QDEPTH = smbrw_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  smbrw_in_if.sink                           in_ch,
  smbrw_out_if.source                        out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [smbrw_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [smbrw_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [smbrw_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import smbrw_pkg::*;

  logic [6:0] dev_addr_r, dev_addr_nxt;
  logic       cfg_wr;
  logic       cfg_hit;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:CFG_INDEX_LSB] == REG_DEVICE_ADDRESS);
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(dev_addr_r) : '0;

  assign dev_addr_nxt = (cfg_wr && cfg_hit) ? cfg_pwdata[6:0] : dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEVICE_ADDRESS_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  smbrw_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  smbrw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (dev_addr_r),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_ch         (out_ch)
  );

endmodule

@@ src/smbrw_front.sv @@
// Front end: accepts input transactions, classifies them and queues commands.
module smbrw_front #(
  parameter int QDEPTH = smbrw_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  smbrw_in_if.sink            in_ch,
  output logic                q_valid,
  output smbrw_pkg::cmd_t     q_cmd,
  input  logic                q_pop
);
  import smbrw_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  cmd_t             in_cmd;

  assign in_ch.ready = (count_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_cmd       = mem_r[rd_ptr_r];

  always_comb begin
    in_cmd.kind     = in_ch.opcode ? CMD_START : CMD_TICK;
    in_cmd.reg_addr = in_ch.reg_addr;
    in_cmd.sda      = in_ch.sda_in;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QDEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on push");
`endif

endmodule

@@ src/smbrw_back.sv @@
// Back end: bus sequencer, CRC-8 accumulation and registered result stage.
module smbrw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          device_address,
  input  logic                q_valid,
  input  smbrw_pkg::cmd_t     q_cmd,
  output logic                q_pop,
  smbrw_out_if.source         out_ch
);
  import smbrw_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_START  = 10'b00_0000_0010,
    ST_WADDR  = 10'b00_0000_0100,
    ST_WREG   = 10'b00_0000_1000,
    ST_RSTART = 10'b00_0001_0000,
    ST_RADDR  = 10'b00_0010_0000,
    ST_RLOW   = 10'b00_0100_0000,
    ST_RHIGH  = 10'b00_1000_0000,
    ST_RPEC   = 10'b01_0000_0000,
    ST_STOP   = 10'b10_0000_0000
  } step_t;

  step_t       step_r, step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [15:0] word_r, word_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_r, res;

  logic        take;
  logic        adv;
  logic        done;
  logic        crc_en;
  logic        crc_clr;
  logic [7:0]  crc_byte;
  logic        bit_pending;
  logic [7:0]  addr_w;

  assign take        = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop       = take;
  assign adv         = (q_cmd.kind == CMD_TICK);
  assign bit_pending = (bit_r < BITS_PER_BYTE);
  assign addr_w      = {device_address, 1'b0};

  always_comb begin
    step_nxt  = step_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    reg_nxt   = reg_r;
    word_nxt  = word_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    err_nxt   = err_r;
    done      = 1'b0;
    crc_en    = 1'b0;
    crc_clr   = 1'b0;
    crc_byte  = 8'h00;

    case (step_r)
      ST_START, ST_RSTART: begin
        if (adv) begin
          if (phase_r == 2'd0) begin
            sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            sda_nxt = 1'b0; phase_nxt = 2'd2;
          end else begin
            scl_nxt   = 1'b0;
            phase_nxt = 2'd0;
            bit_nxt   = '0;
            crc_en    = 1'b1;
            if (step_r == ST_START) begin
              step_nxt = ST_WADDR; shift_nxt = addr_w; crc_byte = addr_w;
            end else begin
              step_nxt = ST_RADDR; shift_nxt = addr_w | 8'h01; crc_byte = addr_w | 8'h01;
            end
          end
        end
      end
      ST_WADDR, ST_WREG, ST_RADDR: begin
        if (adv) begin
          if (phase_r == 2'd0) begin
            sda_nxt   = bit_pending ? shift_r[7] : 1'b1;
            phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            scl_nxt = 1'b1; phase_nxt = 2'd2;
          end else begin
            scl_nxt   = 1'b0;
            phase_nxt = 2'd0;
            if (bit_pending) begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = bit_r + 1'b1;
            end else if (q_cmd.sda) begin
              err_nxt = (step_r == ST_WADDR) ? STATUS_NACK_WADDR :
                        (step_r == ST_WREG)  ? STATUS_NACK_WREG : STATUS_NACK_RADDR;
              step_nxt = ST_STOP;
              bit_nxt  = '0;
            end else if (step_r == ST_WADDR) begin
              step_nxt  = ST_WREG;
              shift_nxt = reg_r;
              crc_en    = 1'b1;
              crc_byte  = reg_r;
              bit_nxt   = '0;
            end else if (step_r == ST_WREG) begin
              step_nxt = ST_RSTART;
              bit_nxt  = '0;
            end else begin
              step_nxt  = ST_RLOW;
              shift_nxt = 8'h00;
              bit_nxt   = '0;
            end
          end
        end
      end
      ST_RLOW, ST_RHIGH, ST_RPEC: begin
        if (adv) begin
          if (bit_pending) begin
            if (phase_r == 2'd0) begin
              sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = 2'd1;
            end else begin
              shift_nxt = {shift_r[6:0], q_cmd.sda};
              scl_nxt   = 1'b0;
              phase_nxt = 2'd0;
              bit_nxt   = bit_r + 1'b1;
            end
          end else if (phase_r == 2'd0) begin
            sda_nxt   = (step_r == ST_RPEC);
            phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            scl_nxt = 1'b1; phase_nxt = 2'd2;
          end else begin
            scl_nxt   = 1'b0;
            phase_nxt = 2'd0;
            bit_nxt   = '0;
            if (step_r == ST_RLOW) begin
              word_nxt  = {8'h00, shift_r};
              crc_en    = 1'b1;
              crc_byte  = shift_r;
              shift_nxt = 8'h00;
              step_nxt  = ST_RHIGH;
            end else if (step_r == ST_RHIGH) begin
              word_nxt  = {shift_r, word_r[7:0]};
              crc_en    = 1'b1;
              crc_byte  = shift_r;
              shift_nxt = 8'h00;
              step_nxt  = ST_RPEC;
            end else begin
              step_nxt = ST_STOP;
            end
          end
        end
      end
      ST_STOP: begin
        if (adv) begin
          if (phase_r == 2'd0) begin
            sda_nxt = 1'b0; phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            scl_nxt = 1'b1; phase_nxt = 2'd2;
          end else begin
            sda_nxt   = 1'b1;
            done      = 1'b1;
            step_nxt  = ST_IDLE;
            phase_nxt = 2'd0;
            bit_nxt   = '0;
          end
        end
      end
      default: begin
        step_nxt = ST_IDLE;
        if (!adv) begin
          reg_nxt   = q_cmd.reg_addr;
          step_nxt  = ST_START;
          phase_nxt = 2'd0;
          bit_nxt   = '0;
          shift_nxt = 8'h00;
          crc_clr   = 1'b1;
          word_nxt  = 16'h0000;
          err_nxt   = STATUS_OK;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
        end
      end
    endcase

    if (crc_clr) begin
      crc_nxt = 8'h00;
    end else if (crc_en) begin
      crc_nxt = crc8_feed(crc_r, crc_byte);
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_comb begin
    res.scl_out   = scl_nxt;
    res.sda_out   = sda_nxt;
    res.busy_res  = (step_nxt != ST_IDLE);
    res.done_res  = done;
    res.status    = done ? err_r : STATUS_OK;
    res.data_word = (done && err_r == STATUS_OK) ? word_r : 16'h0000;
    res.pec_ok    = done && (err_r == STATUS_OK) && (shift_r == crc_r);
  end

  assign out_valid_nxt = take || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      phase_r     <= 2'd0;
      bit_r       <= '0;
      shift_r     <= 8'h00;
      crc_r       <= 8'h00;
      reg_r       <= 8'h00;
      word_r      <= 16'h0000;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      err_r       <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        step_r  <= step_nxt;
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        crc_r   <= crc_nxt;
        reg_r   <= reg_nxt;
        word_r  <= word_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_out   = out_r.scl_out;
  assign out_ch.sda_out   = out_r.sda_out;
  assign out_ch.busy_res  = out_r.busy_res;
  assign out_ch.done_res  = out_r.done_res;
  assign out_ch.status    = out_r.status;
  assign out_ch.data_word = out_r.data_word;
  assign out_ch.pec_ok    = out_r.pec_ok;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.busy_res)
    else $error("done reported while still busy");

  a_report_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != STATUS_OK || out_r.pec_ok || out_r.data_word != 16'h0000)
    |-> out_r.done_res)
    else $error("status or data reported without done");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    take && step_r == ST_IDLE && q_cmd.kind == CMD_TICK
    |=> step_r == ST_IDLE && scl_r == $past(scl_r) && sda_r == $past(sda_r))
    else $error("idle tick changed bus state");
`endif

endmodule

@@ dv/smbus_read_word_pec_master_core_tb.sv @@
// Self-checking testbench for the SMBus read-word master with PEC: predictor, stimulus, checks.
module smbus_read_word_pec_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smbrw_pkg::*;

  typedef enum logic [4:0] {
    SEQ_IDLE   = 5'd0,
    SEQ_START  = 5'd1,
    SEQ_WADDR  = 5'd2,
    SEQ_WREG   = 5'd3,
    SEQ_RSTART = 5'd4,
    SEQ_RADDR  = 5'd5,
    SEQ_RLOW   = 5'd6,
    SEQ_RHIGH  = 5'd7,
    SEQ_RPEC   = 5'd8,
    SEQ_STOP   = 5'd9
  } seq_step_t;

  typedef struct {
    cmd_kind_t  kind;
    logic [7:0] reg_addr;
    logic       sda;
    bit         typed;
    res_t       exp;
  } dir_row_t;

  localparam logic [CFG_ADDR_W-1:0] DEV_ADDR_OFS =
    CFG_ADDR_W'(REG_DEVICE_ADDRESS) << CFG_INDEX_LSB;
  localparam int HOLD_CYCLES = 48;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  smbrw_in_if  in_ch ();
  smbrw_out_if out_ch ();

  smbus_read_word_pec_master_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted bus master state
  logic [6:0]  m_dev;
  seq_step_t   m_step;
  logic [1:0]  m_phase;
  logic [3:0]  m_bits;
  logic [7:0]  m_shift;
  logic [7:0]  m_crc;
  logic [7:0]  m_reg;
  logic [15:0] m_word;
  logic        m_scl;
  logic        m_sda;
  logic [1:0]  m_err;

  // plan for the transaction being generated
  logic [1:0]  plan_fault;
  bit          plan_good_pec;

  res_t        bus_result_q [$];
  int          errors;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          done_cnt;
  dir_row_t    dir_tab [20];

  function automatic logic [7:0] pec_update(logic [7:0] acc, logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0};
      if (fb) r = r ^ 8'h07;
    end
    return r;
  endfunction

  function automatic res_t bus_predict(cmd_t c);
    res_t       r;
    logic [7:0] aw;
    logic       fin;
    aw  = {m_dev, 1'b0};
    fin = 1'b0;
    if (m_step == SEQ_IDLE) begin
      if (c.kind == CMD_START) begin
        m_reg   = c.reg_addr;
        m_step  = SEQ_START;
        m_phase = '0;
        m_bits  = '0;
        m_shift = '0;
        m_crc   = '0;
        m_word  = '0;
        m_err   = STATUS_OK;
        m_scl   = 1'b1;
        m_sda   = 1'b1;
      end
    end else if (c.kind == CMD_TICK) begin
      case (m_step)
        SEQ_START, SEQ_RSTART: begin
          if (m_phase == 2'd0) begin
            m_sda = 1'b1; m_scl = 1'b1; m_phase = 2'd1;
          end else if (m_phase == 2'd1) begin
            m_sda = 1'b0; m_phase = 2'd2;
          end else begin
            m_scl = 1'b0;
            if (m_step == SEQ_START) begin
              m_step = SEQ_WADDR; m_shift = aw;
            end else begin
              m_step = SEQ_RADDR; m_shift = aw | 8'h01;
            end
            m_crc = pec_update(m_crc, m_shift);
            m_phase = '0; m_bits = '0;
          end
        end
        SEQ_WADDR, SEQ_WREG, SEQ_RADDR: begin
          if (m_phase == 2'd0) begin
            m_sda = (m_bits < 4'd8) ? m_shift[7] : 1'b1;
            m_phase = 2'd1;
          end else if (m_phase == 2'd1) begin
            m_scl = 1'b1; m_phase = 2'd2;
          end else begin
            m_scl = 1'b0;
            m_phase = '0;
            if (m_bits < 4'd8) begin
              m_shift = {m_shift[6:0], 1'b0};
              m_bits++;
            end else if (c.sda) begin
              m_err = (m_step == SEQ_WADDR) ? STATUS_NACK_WADDR :
                      (m_step == SEQ_WREG)  ? STATUS_NACK_WREG  : STATUS_NACK_RADDR;
              m_step = SEQ_STOP; m_bits = '0;
            end else if (m_step == SEQ_WADDR) begin
              m_step = SEQ_WREG; m_shift = m_reg; m_crc = pec_update(m_crc, m_reg);
              m_bits = '0;
            end else if (m_step == SEQ_WREG) begin
              m_step = SEQ_RSTART; m_bits = '0;
            end else begin
              m_step = SEQ_RLOW; m_shift = '0; m_bits = '0;
            end
          end
        end
        SEQ_RLOW, SEQ_RHIGH, SEQ_RPEC: begin
          if (m_bits < 4'd8) begin
            if (m_phase == 2'd0) begin
              m_sda = 1'b1; m_scl = 1'b1; m_phase = 2'd1;
            end else begin
              m_shift = {m_shift[6:0], c.sda};
              m_scl = 1'b0; m_phase = '0; m_bits++;
            end
          end else if (m_phase == 2'd0) begin
            m_sda = (m_step == SEQ_RPEC); m_phase = 2'd1;
          end else if (m_phase == 2'd1) begin
            m_scl = 1'b1; m_phase = 2'd2;
          end else begin
            m_scl = 1'b0;
            m_phase = '0; m_bits = '0;
            if (m_step == SEQ_RLOW) begin
              m_word = {8'h00, m_shift};
              m_crc = pec_update(m_crc, m_shift);
              m_step = SEQ_RHIGH; m_shift = '0;
            end else if (m_step == SEQ_RHIGH) begin
              m_word[15:8] = m_shift;
              m_crc = pec_update(m_crc, m_shift);
              m_step = SEQ_RPEC; m_shift = '0;
            end else begin
              m_step = SEQ_STOP;
            end
          end
        end
        SEQ_STOP: begin
          if (m_phase == 2'd0) begin
            m_sda = 1'b0; m_phase = 2'd1;
          end else if (m_phase == 2'd1) begin
            m_scl = 1'b1; m_phase = 2'd2;
          end else begin
            m_sda = 1'b1; fin = 1'b1;
            m_step = SEQ_IDLE; m_phase = '0; m_bits = '0;
          end
        end
        default: m_step = SEQ_IDLE;
      endcase
    end
    r = '0;
    r.scl_out  = m_scl;
    r.sda_out  = m_sda;
    r.busy_res = (m_step != SEQ_IDLE);
    r.done_res = fin;
    if (fin) begin
      r.status    = m_err;
      r.data_word = (m_err == STATUS_OK) ? m_word : 16'h0000;
      r.pec_ok    = (m_err == STATUS_OK) && (m_shift == m_crc);
    end
    return r;
  endfunction

  function automatic res_t line_res(logic scl, logic sda, logic busy);
    res_t r;
    r = '0;
    r.scl_out  = scl;
    r.sda_out  = sda;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, a);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send(cmd_t c, bit typed, res_t typed_res);
    int   gap;
    res_t r;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= c.kind;
    in_ch.reg_addr <= c.reg_addr;
    in_ch.sda_in   <= c.sda;
    do @(posedge clk); while (!in_ch.ready);
    r = bus_predict(c);
    if (r.done_res) done_cnt++;
    bus_result_q.push_back(typed ? typed_res : r);
  endtask

  task automatic settle(int extra);
    in_ch.valid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic dev_addr_write(logic [6:0] v);
    logic [CFG_DATA_W-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= DEV_ADDR_OFS;
    cfg_pwdata  <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    m_dev = v;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== CFG_DATA_W'(v)) begin
      $display("%0t: device_address readback mismatch, expected %h, actual %h",
               $realtime, CFG_DATA_W'(v), rd);
      errors++;
    end
  endtask

  task automatic run_phase(int n_min, int done_min, int hold_at, int pause_at);
    cmd_t c;
    int   items;
    int   k;
    int   done_base;
    items = 0;
    done_base = done_cnt;
    while (items < n_min || (done_cnt - done_base) < done_min || m_step != SEQ_IDLE) begin
      if (m_step == SEQ_IDLE) begin
        if ($urandom_range(99) < 85) begin
          c.kind = CMD_START;
          k = $urandom_range(99);
          plan_fault = (k < 64) ? STATUS_OK : (k < 76) ? STATUS_NACK_WADDR :
                       (k < 88) ? STATUS_NACK_WREG : STATUS_NACK_RADDR;
          plan_good_pec = ($urandom_range(99) < 70);
        end else begin
          c.kind = CMD_TICK;
        end
      end else begin
        c.kind = ($urandom_range(99) < 3) ? CMD_START : CMD_TICK;
      end
      c.reg_addr = 8'($urandom);
      c.sda      = 1'($urandom_range(1));
      if (c.kind == CMD_TICK) begin
        if ((m_step inside {SEQ_WADDR, SEQ_WREG, SEQ_RADDR}) && m_bits == 4'd8 &&
            m_phase == 2'd2) begin
          c.sda = (plan_fault == STATUS_NACK_WADDR && m_step == SEQ_WADDR) ||
                  (plan_fault == STATUS_NACK_WREG  && m_step == SEQ_WREG)  ||
                  (plan_fault == STATUS_NACK_RADDR && m_step == SEQ_RADDR);
        end else if (m_step == SEQ_RPEC && m_bits < 4'd8 && m_phase == 2'd1 &&
                     plan_good_pec) begin
          c.sda = m_crc[7 - m_bits];
        end
      end
      if (items == hold_at) hold_req = 1'b1;
      if (items == pause_at) settle(0);
      send(c, 1'b0, '0);
      items++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check, then decide ready for the next edge
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (bus_result_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $realtime, {out_ch.scl_out, out_ch.sda_out, out_ch.busy_res,
                   out_ch.done_res, out_ch.status, out_ch.data_word, out_ch.pec_ok});
          errors++;
        end else begin
          res_t e;
          bit   ok;
          e = bus_result_q.pop_front();
          ok = field_ok("scl_out", 16'(e.scl_out), 16'(out_ch.scl_out));
          ok &= field_ok("sda_out", 16'(e.sda_out), 16'(out_ch.sda_out));
          ok &= field_ok("busy_res", 16'(e.busy_res), 16'(out_ch.busy_res));
          ok &= field_ok("done_res", 16'(e.done_res), 16'(out_ch.done_res));
          ok &= field_ok("status", 16'(e.status), 16'(out_ch.status));
          ok &= field_ok("data_word", e.data_word, out_ch.data_word);
          ok &= field_ok("pec_ok", 16'(e.pec_ok), 16'(out_ch.pec_ok));
          if (!ok) errors++;
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= CMD_TICK;
    in_ch.reg_addr <= '0;
    in_ch.sda_in   <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    errors         = 0;
    done_cnt       = 0;
    hold_req       = 1'b0;
    snd_idle_pct   = 0;
    rcv_idle_pct   = 30;
    plan_fault     = STATUS_OK;
    plan_good_pec  = 1'b1;
    m_dev   = DEVICE_ADDRESS_RESET;
    m_step  = SEQ_IDLE;
    m_phase = '0;
    m_bits  = '0;
    m_shift = '0;
    m_crc   = '0;
    m_reg   = '0;
    m_word  = '0;
    m_scl   = 1'b1;
    m_sda   = 1'b1;
    m_err   = STATUS_OK;

    dir_tab = '{
      '{CMD_TICK,  8'h00, 1'b0, 1'b1, line_res(1, 1, 0)},
      '{CMD_TICK,  8'hFF, 1'b1, 1'b1, line_res(1, 1, 0)},
      '{CMD_START, 8'hFF, 1'b0, 1'b1, line_res(1, 1, 1)},
      '{CMD_START, 8'h00, 1'b1, 1'b1, line_res(1, 1, 1)},
      '{CMD_TICK,  8'h00, 1'b0, 1'b1, line_res(1, 1, 1)},
      '{CMD_TICK,  8'hA5, 1'b1, 1'b1, line_res(1, 0, 1)},
      '{CMD_TICK,  8'h5A, 1'b0, 1'b1, line_res(0, 0, 1)},
      '{CMD_TICK,  8'h00, 1'b1, 1'b1, line_res(0, 1, 1)},
      '{CMD_TICK,  8'hFF, 1'b0, 1'b1, line_res(1, 1, 1)},
      '{CMD_TICK,  8'h00, 1'b1, 1'b1, line_res(0, 1, 1)},
      '{CMD_START, 8'h5A, 1'b0, 1'b1, line_res(0, 1, 1)},
      '{CMD_TICK,  8'hFF, 1'b1, 1'b1, line_res(0, 0, 1)},
      '{CMD_TICK,  8'h00, 1'b0, 1'b1, line_res(1, 0, 1)},
      '{CMD_TICK,  8'hFF, 1'b1, 1'b1, line_res(0, 0, 1)},
      '{CMD_TICK,  8'h3C, 1'b1, 1'b0, '0},
      '{CMD_TICK,  8'hC3, 1'b0, 1'b0, '0},
      '{CMD_TICK,  8'h0F, 1'b1, 1'b0, '0},
      '{CMD_START, 8'h80, 1'b1, 1'b0, '0},
      '{CMD_TICK,  8'hF0, 1'b0, 1'b0, '0},
      '{CMD_TICK,  8'h01, 1'b1, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      cmd_t c;
      c.kind     = dir_tab[i].kind;
      c.reg_addr = dir_tab[i].reg_addr;
      c.sda      = dir_tab[i].sda;
      send(c, dir_tab[i].typed, dir_tab[i].exp);
    end

    snd_idle_pct = 22;
    rcv_idle_pct = 88;
    run_phase(560, 3, -1, -1);
    settle(4);
    dev_addr_write(7'h7F);

    snd_idle_pct = 88;
    rcv_idle_pct = 22;
    run_phase(560, 3, -1, 300);
    settle(4);
    dev_addr_write(7'h00);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(560, 3, 150, -1);
    settle(10);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
